[sv/timestamp_ordered_request_queue_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the timestamp-ordered request queue
// All checks are clocked on clk_i and are switched off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_ORDERED_REQUEST_QUEUE_TOP_MACROS_SVH
`define TIMESTAMP_ORDERED_REQUEST_QUEUE_TOP_MACROS_SVH

// General check: the property must hold at every clock edge outside reset.
`define TORQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true.
`define TORQ_ASSERT_NEVER(lbl, expr, msg) \
  `TORQ_ASSERT(lbl, !(expr), msg)

`endif

[sv/torq_pkg.sv]
// ---------------------------------------------------------------------------
// torq_pkg
// Shared constants, status codes and the cell command type of the
// timestamp-ordered request queue.
// ---------------------------------------------------------------------------
package torq_pkg;

  // Ranks are six bits wide and unique, so the chain never holds more than
  // one cell per rank.
  localparam int unsigned RankW    = 6;
  localparam int unsigned StampW   = 64;
  localparam int unsigned NumCells = 64;
  localparam int unsigned IdxW     = $clog2(NumCells);
  localparam int unsigned CntW     = $clog2(NumCells + 1);
  localparam int unsigned StatusW  = 3;

  // Result status codes.
  localparam logic [StatusW-1:0] StInserted  = 3'd0;
  localparam logic [StatusW-1:0] StDuplicate = 3'd1;
  localparam logic [StatusW-1:0] StFull      = 3'd2;
  localparam logic [StatusW-1:0] StRemoved   = 3'd3;
  localparam logic [StatusW-1:0] StNotFound  = 3'd4;

  // Command broadcast to every cell in the update cycle.
  typedef struct packed {
    logic              ins;    // open a gap at pos and load the new entry
    logic              rem;    // close up the chain from pos onwards
    logic [IdxW-1:0]   pos;
    logic [RankW-1:0]  rank;   // new entry for an insert
    logic [StampW-1:0] stamp;
  } torq_cmd_t;

endpackage

[sv/timestamp_ordered_request_queue_top.sv]
// ---------------------------------------------------------------------------
// timestamp_ordered_request_queue_top
// Sorted queue of (rank, timestamp) requests held in a chain of 64 cells.
// Inserts open a gap at the sorted place, removals close the chain up.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ----------------------------------------------
//  command   start_i, busy_o    action_i, rank_i, stamp_i, group_end_i
//  result    done_o (strobe)    status_o, found_o, position_o, occupancy_o,
//                               group_done_o
//
//  A command beat is taken when start_i is high and busy_o is low. It runs
//  through an evaluate cycle (every cell compares itself with the key) and an
//  update cycle (every cell shifts with its neighbours); busy_o is high through
//  both, so a new beat is taken only once the block is idle again. The result
//  appears with done_o in the cycle after the update, in which the next beat
//  may already be taken. The receiver cannot stall the result. Reset empties the
//  queue at once; cell contents are not cleared.
//
module timestamp_ordered_request_queue_top
  import torq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  logic [RankW-1:0]   rank_i,
  input  logic [StampW-1:0]  stamp_i,
  input  logic               group_end_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic               found_o,
  output logic [IdxW-1:0]    position_o,
  output logic [CntW-1:0]    occupancy_o,
  output logic               group_done_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEval   = 2'd1;
  localparam logic [1:0] StUpdate = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               action_q;
  logic [RankW-1:0]   rank_q;
  logic [StampW-1:0]  stamp_q;
  logic               gend_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               hit_q;
  logic [IdxW-1:0]    at_q, ins_pos_q;
  logic               done_q;
  logic [StatusW-1:0] status_q, status_d;
  logic               found_q, found_d;
  logic [IdxW-1:0]    pos_q, pos_d;
  logic               gdone_q;

  logic [NumCells-1:0] match_vec, after_vec, first_after;
  logic [IdxW-1:0]     at_enc, ins_enc;
  logic                accept;
  torq_cmd_t           cmd;

  logic [RankW-1:0]  cell_rank  [NumCells];
  logic [StampW-1:0] cell_stamp [NumCells];

  assign accept = start_i && (state_q == StIdle);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StEval;
      StEval:   state_d = StUpdate;
      StUpdate: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      rank_q   <= rank_i;
      stamp_q  <= stamp_i;
      gend_q   <= group_end_i;
    end
  end

  // The cell chain.
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    logic [RankW-1:0]  l_rank, r_rank;
    logic [StampW-1:0] l_stamp, r_stamp;

    if (gi == 0) begin : g_first
      assign l_rank  = '0;
      assign l_stamp = '0;
    end else begin : g_mid_l
      assign l_rank  = cell_rank[gi-1];
      assign l_stamp = cell_stamp[gi-1];
    end

    if (gi == NumCells - 1) begin : g_last
      assign r_rank  = '0;
      assign r_stamp = '0;
    end else begin : g_mid_r
      assign r_rank  = cell_rank[gi+1];
      assign r_stamp = cell_stamp[gi+1];
    end

    torq_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IdxW'(gi)),
      .count_i      (count_q),
      .key_rank_i   (rank_q),
      .key_stamp_i  (stamp_q),
      .cmd_i        (cmd),
      .left_rank_i  (l_rank),
      .left_stamp_i (l_stamp),
      .right_rank_i (r_rank),
      .right_stamp_i(r_stamp),
      .rank_o       (cell_rank[gi]),
      .stamp_o      (cell_stamp[gi]),
      .match_o      (match_vec[gi]),
      .after_o      (after_vec[gi])
    );
  end

  // The insert place is the first cell of the tail that sorts after the key.
  assign first_after = after_vec & ~{after_vec[NumCells-2:0], 1'b0};

  // One-hot to index encoders for the matching cell and the insert place.
  always_comb begin
    at_enc  = '0;
    ins_enc = '0;
    for (int i = 0; i < NumCells; i++) begin
      if (match_vec[i]) at_enc = at_enc | IdxW'(i);
      if (first_after[i]) ins_enc = ins_enc | IdxW'(i);
    end
  end

  // Evaluate results, registered for the update cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == StEval) begin
      hit_q     <= |match_vec;
      at_q      <= at_enc;
      ins_pos_q <= ins_enc;
    end
  end

  // Decision of the update cycle: cell command, status and new fill count.
  always_comb begin
    cmd       = '0;
    cmd.rank  = rank_q;
    cmd.stamp = stamp_q;
    count_d   = count_q;
    status_d  = StNotFound;
    found_d   = 1'b0;
    pos_d     = '0;
    if (!action_q) begin
      if (hit_q) begin
        status_d = StDuplicate;
        found_d  = 1'b1;
        pos_d    = at_q;
      end else if (count_q == CntW'(NumCells)) begin
        status_d = StFull;
      end else begin
        status_d = StInserted;
        found_d  = 1'b1;
        pos_d    = ins_pos_q;
        cmd.ins  = (state_q == StUpdate);
        cmd.pos  = ins_pos_q;
        count_d  = count_q + 1'b1;
      end
    end else if (hit_q) begin
      status_d = StRemoved;
      cmd.rem  = (state_q == StUpdate);
      cmd.pos  = at_q;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == StUpdate);
      if (state_q == StUpdate) begin
        count_q <= count_d;
      end
    end
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (state_q == StUpdate) begin
      status_q <= status_d;
      found_q  <= found_d;
      pos_q    <= pos_d;
      gdone_q  <= gend_q;
    end
  end

  assign busy_o       = (state_q != StIdle);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign position_o   = pos_q;
  assign occupancy_o  = count_q;
  assign group_done_o = gdone_q;

  // Checks.
  `include "timestamp_ordered_request_queue_top_macros.svh"

  `TORQ_ASSERT(a_done_after_update, (state_q == StUpdate) |=> done_o, "result beat missing after update")
  `TORQ_ASSERT_NEVER(a_count_range, count_q > CntW'(NumCells), "fill count beyond cell count")
  `TORQ_ASSERT(a_single_match, $onehot0(match_vec), "rank held in more than one cell")
  `TORQ_ASSERT(a_single_place, $onehot0(first_after), "insert place not unique")
  `TORQ_ASSERT(a_count_step, done_o |-> ((occupancy_o == $past(count_q)) || (occupancy_o == $past(count_q) + 1'b1) || (occupancy_o + 1'b1 == $past(count_q))), "fill count moved by more than one")

endmodule

[sv/torq_cell.sv]
// ---------------------------------------------------------------------------
// torq_cell
// One place of the sorted queue. Holds a rank and a timestamp, compares
// them with the item under evaluation and shifts with its neighbours.
// ---------------------------------------------------------------------------
module torq_cell
  import torq_pkg::*;
(
  input  logic              clk_i,
  input  logic [IdxW-1:0]   idx_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [RankW-1:0]  key_rank_i,
  input  logic [StampW-1:0] key_stamp_i,
  input  torq_cmd_t         cmd_i,
  input  logic [RankW-1:0]  left_rank_i,
  input  logic [StampW-1:0] left_stamp_i,
  input  logic [RankW-1:0]  right_rank_i,
  input  logic [StampW-1:0] right_stamp_i,
  output logic [RankW-1:0]  rank_o,
  output logic [StampW-1:0] stamp_o,
  output logic              match_o,
  output logic              after_o
);

  logic [RankW-1:0]  rank_q, rank_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic              occ;

  // The cell holds a live entry when it lies below the fill count.
  assign occ = ({1'b0, idx_i} < count_i);

  // Same rank held here.
  assign match_o = occ && (rank_q == key_rank_i);

  // The key sorts before this cell's entry, or the cell is empty. Over the
  // chain this flag is set on a tail of cells, whose first is the insert place.
  assign after_o = !occ || (key_stamp_i < stamp_q) ||
                   ((key_stamp_i == stamp_q) && (key_rank_i < rank_q));

  // Shift with the neighbours on an update beat.
  always_comb begin
    rank_d  = rank_q;
    stamp_d = stamp_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.pos) begin
        rank_d  = cmd_i.rank;
        stamp_d = cmd_i.stamp;
      end else if (idx_i > cmd_i.pos) begin
        rank_d  = left_rank_i;
        stamp_d = left_stamp_i;
      end
    end else if (cmd_i.rem) begin
      if (idx_i >= cmd_i.pos) begin
        rank_d  = right_rank_i;
        stamp_d = right_stamp_i;
      end
    end
  end

  // Entry storage; contents past the fill count are never used.
  always_ff @(posedge clk_i) begin
    rank_q  <= rank_d;
    stamp_q <= stamp_d;
  end

  assign rank_o  = rank_q;
  assign stamp_o = stamp_q;

endmodule

[sim/tb_timestamp_ordered_request_queue_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_timestamp_ordered_request_queue_top
// Self-checking bench for the timestamp-ordered request queue. Insert and
// remove beats are driven with random gaps. A behavioural copy of the sorted
// queue predicts every result, and each strobed result is compared with the
// oldest prediction.
// ---------------------------------------------------------------------------
module tb_timestamp_ordered_request_queue_top;
  import torq_pkg::*;

  // Command actions and stimulus phases.
  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;
  localparam int   PhFill    = 0;
  localparam int   PhDrain   = 1;
  localparam int   PhMixed   = 2;

  localparam int   NumBeats  = 800;
  localparam int   IdleLimit = 1000;
  localparam int   MaxShown  = 10;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [StampW-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               found;
    logic [IdxW-1:0]    position;
    logic [CntW-1:0]    occupancy;
    logic               group_done;
  } reply_t;

  // Sorted queue shadow and the results still owed by the block.
  class request_queue_board;
    slot_t  slots[$];
    reply_t awaited_replies[$];
    int     mismatches;

    // Applies one command to the shadow queue and returns its result.
    function reply_t apply_request(logic act, logic [RankW-1:0] rk,
                                   logic [StampW-1:0] st, logic ge);
      reply_t r;
      slot_t  s;
      int     at;
      int     p;
      r = '0;
      r.group_done = ge;
      at = -1;
      foreach (slots[i]) begin
        if (slots[i].rank == rk && at < 0) at = i;
      end
      if (act == ActInsert) begin
        if (at >= 0) begin
          // The queued entry keeps its original stamp.
          r.status   = StDuplicate;
          r.found    = 1'b1;
          r.position = IdxW'(at);
        end else if (slots.size() >= NumCells) begin
          r.status = StFull;
        end else begin
          // Ascending stamp; equal stamps ordered by ascending rank.
          p = slots.size();
          for (int i = 0; i < slots.size(); i++) begin
            if (st < slots[i].stamp || (st == slots[i].stamp && rk < slots[i].rank)) begin
              p = i;
              break;
            end
          end
          s.rank  = rk;
          s.stamp = st;
          slots.insert(p, s);
          r.status   = StInserted;
          r.found    = 1'b1;
          r.position = IdxW'(p);
        end
      end else begin
        if (at >= 0) begin
          slots.delete(at);
          r.status = StRemoved;
        end else begin
          r.status = StNotFound;
        end
      end
      r.occupancy = CntW'(slots.size());
      return r;
    endfunction

    function void note_request(logic act, logic [RankW-1:0] rk,
                               logic [StampW-1:0] st, logic ge);
      awaited_replies.push_back(apply_request(act, rk, st, ge));
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      bit     bad;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("%0t: result with no command outstanding: status %0d pos %0d occ %0d",
                   $realtime, got.status, got.position, got.occupancy);
        return;
      end
      want = awaited_replies.pop_front();
      bad  = (got.status !== want.status) || (got.found !== want.found) ||
             (got.position !== want.position) || (got.occupancy !== want.occupancy) ||
             (got.group_done !== want.group_done);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display({"%0t: mismatch: expected st %0d fnd %0b pos %0d occ %0d gd %0b,",
                    " got st %0d fnd %0b pos %0d occ %0d gd %0b"},
                   $realtime, want.status, want.found, want.position, want.occupancy,
                   want.group_done, got.status, got.found, got.position, got.occupancy,
                   got.group_done);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               action_i;
  logic [RankW-1:0]   rank_i;
  logic [StampW-1:0]  stamp_i;
  logic               group_end_i;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic               found_o;
  logic [IdxW-1:0]    position_o;
  logic [CntW-1:0]    occupancy_o;
  logic               group_done_o;

  request_queue_board board = new();
  int                 idle_cycles;
  int                 sent;
  bit                 idle_on;
  bit [63:0]          queued;

  timestamp_ordered_request_queue_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .rank_i       (rank_i),
    .stamp_i      (stamp_i),
    .group_end_i  (group_end_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .position_o   (position_o),
    .occupancy_o  (occupancy_o),
    .group_done_o (group_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both channels at each edge; results are checked before the beat
  // taken at the same edge is noted, as they belong to earlier beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        board.check_reply(reply_t'{status_o, found_o, position_o, occupancy_o,
                                   group_done_o});
      if (start_i && !busy_o)
        board.note_request(action_i, rank_i, stamp_i, group_end_i);
      if (done_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Ends a run in which the block has stopped taking beats or answering.
  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("FAIL timestamp_ordered_request_queue_top");
    $finish;
  end

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small stamps give plenty of ties; the rest cover the whole range.
  function automatic logic [StampW-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return StampW'($urandom_range(0, 15));
      4, 5:       return {$urandom, $urandom};
      6:          return '1;
      7:          return '0;
      8:          return '1 - StampW'($urandom_range(0, 7));
      default:    return {$urandom, 32'd0} | StampW'($urandom_range(0, 3));
    endcase
  endfunction

  // Finds a rank that is, or is not, queued; any rank if none qualifies.
  function automatic logic [RankW-1:0] pick_rank(bit want_held);
    int base;
    base = $urandom_range(0, 63);
    for (int k = 0; k < 64; k++) begin
      if (queued[(base + k) % 64] == want_held) return RankW'((base + k) % 64);
    end
    return RankW'(base);
  endfunction

  // Drives one command beat and waits until the block takes it.
  task automatic issue(input logic act, input logic [RankW-1:0] rk,
                       input logic [StampW-1:0] st, input logic ge);
    int gap;
    gap = pick_gap();
    start_i     <= 1'b1;
    action_i    <= act;
    rank_i      <= rk;
    stamp_i     <= st;
    group_end_i <= ge;
    do @(posedge clk_i); while (busy_o);
    queued[rk] = (act == ActInsert);
    sent++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int kind;
    int len;
    int roll;
    int ins_abs;
    int ins_dup;
    int rem_pres;
    int failures;
    logic ge;

    start_i     <= 1'b0;
    action_i    <= ActInsert;
    rank_i      <= '0;
    stamp_i     <= '0;
    group_end_i <= 1'b0;
    rst_ni      <= 1'b0;
    idle_cycles = 0;
    sent        = 0;
    queued      = '0;
    idle_on     = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty queue, ties, extremes, duplicates, head, middle
    // and tail removals, and the group mark on both actions.
    issue(ActRemove, 6'd0,  '0, 1'b1);
    issue(ActInsert, 6'd0,  '0, 1'b0);
    issue(ActInsert, 6'd63, '1, 1'b0);
    issue(ActInsert, 6'd5,  '0, 1'b0);
    issue(ActInsert, 6'd2,  '0, 1'b0);
    issue(ActInsert, 6'd63, '0, 1'b1);
    issue(ActInsert, 6'd10, 64'h8000_0000_0000_0000, 1'b0);
    issue(ActInsert, 6'd42, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    issue(ActInsert, 6'd21, '1, 1'b0);
    issue(ActRemove, 6'd2,  '1, 1'b0);
    issue(ActRemove, 6'd0,  '0, 1'b1);
    issue(ActRemove, 6'd63, '0, 1'b0);
    issue(ActRemove, 6'd63, '0, 1'b0);
    issue(ActInsert, 6'd0,  64'h5555_5555_5555_5555, 1'b1);
    issue(ActInsert, 6'd31, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    issue(ActRemove, 6'd21, '0, 1'b0);
    issue(ActRemove, 6'd10, '0, 1'b0);
    issue(ActRemove, 6'd42, '0, 1'b0);
    issue(ActRemove, 6'd5,  '0, 1'b0);
    issue(ActRemove, 6'd31, '0, 1'b0);
    issue(ActRemove, 6'd0,  '0, 1'b1);
    issue(ActInsert, 6'd1,  '0, 1'b0);

    // Random part in phases that fill the queue towards all 64 ranks, drain it,
    // or churn it. Duplicates and removals of absent ranks are the noise.
    // A full drop needs a new rank while all 64 are queued, so it cannot
    // occur with six-bit ranks.
    while (sent < NumBeats) begin
      kind    = $urandom_range(PhFill, PhMixed);
      len     = $urandom_range(20, 120);
      idle_on = ($urandom_range(0, 3) != 0);
      case (kind)
        PhFill: begin
          ins_abs = 80; ins_dup = 85; rem_pres = 95;
        end
        PhDrain: begin
          ins_abs = 7; ins_dup = 12; rem_pres = 92;
        end
        default: begin
          ins_abs = 40; ins_dup = 50; rem_pres = 90;
        end
      endcase
      for (int n = 0; n < len && sent < NumBeats; n++) begin
        roll = $urandom_range(0, 99);
        ge   = ($urandom_range(0, 3) == 0);
        if (roll < ins_abs)       issue(ActInsert, pick_rank(1'b0), pick_stamp(), ge);
        else if (roll < ins_dup)  issue(ActInsert, pick_rank(1'b1), pick_stamp(), ge);
        else if (roll < rem_pres) issue(ActRemove, pick_rank(1'b1), pick_stamp(), ge);
        else                      issue(ActRemove, pick_rank(1'b0), pick_stamp(), ge);
      end
    end

    // Let the last results drain, then watch for any result beyond those owed.
    start_i <= 1'b0;
    while (board.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    failures = board.mismatches + board.awaited_replies.size();
    if (failures == 0) begin
      $display("PASS timestamp_ordered_request_queue_top");
    end else begin
      $display("FAIL timestamp_ordered_request_queue_top");
    end
    $finish;
  end

endmodule
